// ===== hw/rtl/cht_pkg.sv =====
// Shared types and constants of the capability handle table.
// Request, result and table entry layouts, kind and status codes, FSM states.
// No dependencies.
package cht_pkg;

    localparam int unsigned TABLE_SLOTS_DEF = 256;
    localparam int unsigned ROW_BITS        = 32;
    localparam int unsigned ROW_BIT_W       = 5;
    localparam logic [31:0] RIGHTS_MASK_RST = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        KIND_ALLOC       = 3'd0,
        KIND_LOOKUP      = 3'd1,
        KIND_READ_FLAGS  = 3'd2,
        KIND_WRITE_FLAGS = 3'd3,
        KIND_INSTALL     = 3'd4,
        KIND_REMOVE      = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_INVAL  = 3'd1,
        ST_NOENT  = 3'd2,
        ST_ACCESS = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] handle;
        logic [31:0] object_id;
        logic [3:0]  object_type;
        logic [31:0] rights;
        logic [31:0] demand_rights;
        logic [31:0] new_flags;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  handle_index;
        logic [31:0] found_object;
        logic [31:0] entry_flags;
        logic [31:0] entry_rights;
        logic        reference_taken;
        logic [31:0] released_object;
    } result_t;

    typedef struct packed {
        logic [31:0] generation;
        logic [31:0] flags;
        logic [31:0] rights;
        logic [3:0]  otype;
        logic [31:0] object_id;
    } entry_t;

    // Outcome of the first-free search over one row of used bits
    typedef struct packed {
        logic                 found;
        logic [ROW_BIT_W-1:0] pos;
    } map_scan_t;

endpackage

// ===== hw/rtl/cht_entry_ram.sv =====
// Slot entry memory: one write port, one read port with registered data.
// Holds generation, flags, rights, type and object of every slot.
// Depends on cht_pkg.
module cht_entry_ram #(
    parameter int unsigned TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0]  rd_addr,
    output cht_pkg::entry_t                 rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0]  wr_addr,
    input  cht_pkg::entry_t                 wr_data
);
    import cht_pkg::*;

    entry_t mem [TABLE_SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/cht_used_map.sv =====
// Used-slot bitmap, 32 slots to a row, in a memory with registered read.
// Finds the lowest free slot of the row last read. Depends on cht_pkg.
module cht_used_map #(
    parameter int unsigned TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rd_en,
    input  logic [(((TABLE_SLOTS + cht_pkg::ROW_BITS - 1) / cht_pkg::ROW_BITS) > 1 ?
                  $clog2((TABLE_SLOTS + cht_pkg::ROW_BITS - 1) / cht_pkg::ROW_BITS) : 1)-1:0]
                                                   rd_addr,
    output logic [cht_pkg::ROW_BITS-1:0]           rd_data,
    output cht_pkg::map_scan_t                     scan,
    input  logic                                   wr_en,
    input  logic [(((TABLE_SLOTS + cht_pkg::ROW_BITS - 1) / cht_pkg::ROW_BITS) > 1 ?
                  $clog2((TABLE_SLOTS + cht_pkg::ROW_BITS - 1) / cht_pkg::ROW_BITS) : 1)-1:0]
                                                   wr_addr,
    input  logic [cht_pkg::ROW_BITS-1:0]           wr_data
);
    import cht_pkg::*;

    localparam int unsigned ROW_CNT   = (TABLE_SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned ROW_W     = (ROW_CNT > 1) ? $clog2(ROW_CNT) : 1;
    localparam int unsigned ROW_DEPTH = 1 << ROW_W;
    localparam int unsigned LAST_BITS = TABLE_SLOTS - ROW_BITS * (ROW_CNT - 1);
    localparam logic [ROW_BITS-1:0] LAST_MASK = {ROW_BITS{1'b1}} >> (ROW_BITS - LAST_BITS);

    logic [ROW_BITS-1:0] mem [ROW_DEPTH];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic [ROW_W-1:0]    rd_row_reg;
    logic [ROW_BITS-1:0] row_mask;
    logic [ROW_BITS-1:0] avail;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_row_reg  <= rd_addr;
        end
    end

    assign rd_data = rd_data_reg;

    // Slots past the end of the table in the last row never count as free
    assign row_mask = (rd_row_reg == ROW_W'(ROW_CNT - 1)) ? LAST_MASK : {ROW_BITS{1'b1}};
    assign avail    = ~rd_data_reg & row_mask;

    always_comb
    begin
        scan = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                scan.found = 1'b1;
                scan.pos   = ROW_BIT_W'(b);
            end
        end
    end

endmodule

// ===== hw/rtl/cht_ctrl.sv =====
// Request sequencer: clearing pass, free-slot scan, read-modify-write of one
// slot, result register with a hold stage. Depends on cht_pkg.
module cht_ctrl #(
    parameter int unsigned TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [31:0]                            cfg_write_data,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  cht_pkg::req_t                          req,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output cht_pkg::result_t                       rsp,
    output logic                                   ent_rd_en,
    output logic [$clog2(TABLE_SLOTS)-1:0]         ent_rd_addr,
    input  cht_pkg::entry_t                        ent_rd_data,
    output logic                                   ent_wr_en,
    output logic [$clog2(TABLE_SLOTS)-1:0]         ent_wr_addr,
    output cht_pkg::entry_t                        ent_wr_data,
    output logic                                   map_rd_en,
    output logic [(((TABLE_SLOTS + cht_pkg::ROW_BITS - 1) / cht_pkg::ROW_BITS) > 1 ?
                  $clog2((TABLE_SLOTS + cht_pkg::ROW_BITS - 1) / cht_pkg::ROW_BITS) : 1)-1:0]
                                                   map_rd_addr,
    input  logic [cht_pkg::ROW_BITS-1:0]           map_rd_data,
    input  cht_pkg::map_scan_t                     map_scan,
    output logic                                   map_wr_en,
    output logic [(((TABLE_SLOTS + cht_pkg::ROW_BITS - 1) / cht_pkg::ROW_BITS) > 1 ?
                  $clog2((TABLE_SLOTS + cht_pkg::ROW_BITS - 1) / cht_pkg::ROW_BITS) : 1)-1:0]
                                                   map_wr_addr,
    output logic [cht_pkg::ROW_BITS-1:0]           map_wr_data
);
    import cht_pkg::*;

    localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int unsigned ROW_CNT = (TABLE_SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned ROW_W   = (ROW_CNT > 1) ? $clog2(ROW_CNT) : 1;
    localparam int unsigned IDX_W   = ROW_W + ROW_BIT_W;

    state_t         state_reg, state_next;
    req_t           req_reg, req_next;
    logic [15:0]    tgt_reg, tgt_next;
    logic           range_reg, range_next;
    logic [ROW_W-1:0] scan_reg, scan_next;
    logic           full_reg, full_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    result_t        res_reg, res_next;
    result_t        rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;
    logic [31:0]    rights_mask_reg;

    result_t        res_c;
    entry_t         ent_wd_c;
    entry_t         filled_c;
    logic           we_c;
    logic           used_new_c;
    logic           used_c;
    logic           live_c;
    logic [ROW_BITS-1:0] map_wd_c;
    logic [IDX_W-1:0] found_idx;
    logic           out_free;

    function automatic logic alloc_bad(req_t r, logic [31:0] mask);
        alloc_bad = (r.object_id == '0) || (r.object_type == '0)
                    || ((r.rights & ~mask) != '0);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            rights_mask_reg <= RIGHTS_MASK_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write_en)
            begin
                rights_mask_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        tgt_reg   <= tgt_next;
        range_reg <= range_next;
        scan_reg  <= scan_next;
        full_reg  <= full_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    // Evaluate the request against the slot read back from both memories
    always_comb
    begin
        used_c   = map_rd_data[tgt_reg[ROW_BIT_W-1:0]];
        live_c   = used_c && (ent_rd_data.object_id != '0) && (ent_rd_data.otype != '0);
        filled_c.generation = ent_rd_data.generation + 32'd1;
        filled_c.flags      = '0;
        filled_c.rights     = req_reg.rights;
        filled_c.otype      = req_reg.object_type;
        filled_c.object_id  = req_reg.object_id;
        res_c              = '0;
        res_c.status       = ST_INVAL;
        res_c.handle_index = req_reg.handle[7:0];
        we_c       = 1'b0;
        used_new_c = used_c;
        ent_wd_c   = ent_rd_data;
        unique case (req_reg.kind)
            KIND_ALLOC:
            begin
                res_c.handle_index = '0;
                if (alloc_bad(req_reg, rights_mask_reg))
                begin
                    res_c.status = ST_INVAL;
                end
                else if (full_reg)
                begin
                    res_c.status = ST_FULL;
                end
                else
                begin
                    res_c.status          = ST_OK;
                    res_c.handle_index    = tgt_reg[7:0];
                    res_c.reference_taken = 1'b1;
                    we_c       = 1'b1;
                    used_new_c = 1'b1;
                    ent_wd_c   = filled_c;
                end
            end
            KIND_LOOKUP:
            begin
                if (!range_reg)
                begin
                    res_c.status = ST_NOENT;
                end
                else if ((req_reg.demand_rights & ~rights_mask_reg) != '0)
                begin
                    res_c.status = ST_INVAL;
                end
                else if (!live_c)
                begin
                    res_c.status = ST_NOENT;
                end
                else if ((ent_rd_data.rights & req_reg.demand_rights)
                         != req_reg.demand_rights)
                begin
                    res_c.status = ST_ACCESS;
                end
                else
                begin
                    res_c.status          = ST_OK;
                    res_c.found_object    = ent_rd_data.object_id;
                    res_c.entry_flags     = ent_rd_data.flags;
                    res_c.entry_rights    = ent_rd_data.rights;
                    res_c.reference_taken = 1'b1;
                end
            end
            KIND_READ_FLAGS:
            begin
                if (!range_reg || !used_c)
                begin
                    res_c.status = ST_NOENT;
                end
                else
                begin
                    res_c.status      = ST_OK;
                    res_c.entry_flags = ent_rd_data.flags;
                end
            end
            KIND_WRITE_FLAGS:
            begin
                if (!range_reg || !used_c)
                begin
                    res_c.status = ST_NOENT;
                end
                else
                begin
                    res_c.status   = ST_OK;
                    we_c           = 1'b1;
                    ent_wd_c.flags = req_reg.new_flags;
                end
            end
            KIND_INSTALL:
            begin
                if ((req_reg.object_id == '0) || !range_reg || (req_reg.object_type == '0))
                begin
                    res_c.status = ST_INVAL;
                end
                else
                begin
                    res_c.status          = ST_OK;
                    res_c.reference_taken = 1'b1;
                    if (used_c && (ent_rd_data.object_id != '0))
                    begin
                        res_c.released_object = ent_rd_data.object_id;
                    end
                    we_c       = 1'b1;
                    used_new_c = 1'b1;
                    ent_wd_c   = filled_c;
                end
            end
            KIND_REMOVE:
            begin
                if (!range_reg || !live_c)
                begin
                    res_c.status = ST_NOENT;
                end
                else
                begin
                    res_c.status       = ST_OK;
                    res_c.found_object = ent_rd_data.object_id;
                    we_c       = 1'b1;
                    used_new_c = 1'b0;
                    ent_wd_c            = '0;
                    ent_wd_c.generation = ent_rd_data.generation;
                end
            end
            default:
            begin
                res_c.status = ST_INVAL;
            end
        endcase
        map_wd_c = map_rd_data;
        map_wd_c[tgt_reg[ROW_BIT_W-1:0]] = used_new_c;
    end

    assign found_idx = {scan_reg, map_scan.pos};
    assign out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        tgt_next       = tgt_reg;
        range_next     = range_reg;
        scan_next      = scan_reg;
        full_next      = full_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        ent_rd_en      = 1'b0;
        ent_rd_addr    = req.handle[SLOT_W-1:0];
        ent_wr_en      = 1'b0;
        ent_wr_addr    = tgt_reg[SLOT_W-1:0];
        ent_wr_data    = ent_wd_c;
        map_rd_en      = 1'b0;
        map_rd_addr    = req.handle[ROW_BIT_W +: ROW_W];
        map_wr_en      = 1'b0;
        map_wr_addr    = tgt_reg[ROW_BIT_W +: ROW_W];
        map_wr_data    = map_wd_c;
        unique case (state_reg)
            S_CLEAR:
            begin
                // Zero one slot and one bitmap row per cycle
                ent_wr_en   = 1'b1;
                ent_wr_addr = clr_reg;
                ent_wr_data = '0;
                map_wr_en   = 1'b1;
                map_wr_addr = clr_reg[ROW_W-1:0];
                map_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    tgt_next   = req.handle;
                    range_next = ({1'b0, req.handle} < 17'(TABLE_SLOTS));
                    full_next  = 1'b0;
                    scan_next  = '0;
                    ent_rd_en  = 1'b1;
                    map_rd_en  = 1'b1;
                    if (req.kind == KIND_ALLOC)
                    begin
                        map_rd_addr = '0;
                        state_next  = alloc_bad(req, rights_mask_reg) ? S_EVAL : S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_SCAN:
            begin
                if (map_scan.found)
                begin
                    // Keep this row in the bitmap read register for the write-back
                    tgt_next    = 16'(found_idx);
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = found_idx[SLOT_W-1:0];
                    state_next  = S_EVAL;
                end
                else if (scan_reg == ROW_W'(ROW_CNT - 1))
                begin
                    full_next  = 1'b1;
                    state_next = S_EVAL;
                end
                else
                begin
                    scan_next   = scan_reg + 1'b1;
                    map_rd_en   = 1'b1;
                    map_rd_addr = scan_reg + 1'b1;
                end
            end
            S_EVAL:
            begin
                ent_wr_en = we_c;
                map_wr_en = we_c;
                if (out_free)
                begin
                    rsp_next       = res_c;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    res_next   = res_c;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_map_with_entry: assert property (@(posedge clk) disable iff (!rst_n)
        map_wr_en |-> ent_wr_en)
        else $error("bitmap written without the slot entry");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ent_wr_en |-> (state_reg == S_EVAL || state_reg == S_CLEAR))
        else $error("slot entry written outside evaluate or clear");

    a_push_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> rsp_valid_reg)
        else $error("result held back while the output register is empty");

    a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.reference_taken) |-> (rsp_reg.status == ST_OK))
        else $error("reference taken on a failed request");

    a_scan_from_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (req_reg.kind == KIND_ALLOC))
        else $error("free-slot scan for a request other than allocate");

endmodule

// ===== hw/rtl/capability_handle_table_top.sv =====
// Capability handle table: slot entries plus used bitmap, both in RAMs with registered read.
// Request/result channels with valid/ready, one rights mask register.
// Depends on cht_pkg, cht_entry_ram, cht_used_map, cht_ctrl.

// After reset the block runs a clearing pass, one slot per cycle, and accepts
// no request until it ends; the rights mask register can be written throughout.
// A request's slot entry and its bitmap row are read in the accept cycle; for
// any request but an allocate that passes its argument checks, the next cycle
// checks, writes back and loads the result register, or the hold register while
// the output register is occupied, and no request is accepted before then. An
// allocate that passes them first reads the 32-slot rows of the used bitmap in
// order, up to and including the row holding the first free slot (all rows if
// the table is full), then that slot's entry, and is then checked the same way.
// One result waiting on rsp_ready does not stop the next request being taken;
// a second one holds the request side until the output register frees.
module capability_handle_table_top #(
    parameter int unsigned TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  kind,
    input  logic [15:0] handle,
    input  logic [31:0] object_id,
    input  logic [3:0]  object_type,
    input  logic [31:0] rights,
    input  logic [31:0] demand_rights,
    input  logic [31:0] new_flags,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  status,
    output logic [7:0]  handle_index,
    output logic [31:0] found_object,
    output logic [31:0] entry_flags,
    output logic [31:0] entry_rights,
    output logic        reference_taken,
    output logic [31:0] released_object
);
    import cht_pkg::*;

    localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int unsigned ROW_CNT = (TABLE_SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned ROW_W   = (ROW_CNT > 1) ? $clog2(ROW_CNT) : 1;

    req_t              req;
    result_t           rsp;
    logic              ent_rd_en;
    logic [SLOT_W-1:0] ent_rd_addr;
    entry_t            ent_rd_data;
    logic              ent_wr_en;
    logic [SLOT_W-1:0] ent_wr_addr;
    entry_t            ent_wr_data;
    logic              map_rd_en;
    logic [ROW_W-1:0]  map_rd_addr;
    logic [ROW_BITS-1:0] map_rd_data;
    map_scan_t         map_scan;
    logic              map_wr_en;
    logic [ROW_W-1:0]  map_wr_addr;
    logic [ROW_BITS-1:0] map_wr_data;

    assign req.kind            = kind;
    assign req.handle          = handle;
    assign req.object_id       = object_id;
    assign req.object_type     = object_type;
    assign req.rights          = rights;
    assign req.demand_rights   = demand_rights;
    assign req.new_flags       = new_flags;

    cht_entry_ram #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data)
    );

    cht_used_map #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_used_map (
        .clk     (clk),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .scan    (map_scan),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    cht_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .ent_rd_en      (ent_rd_en),
        .ent_rd_addr    (ent_rd_addr),
        .ent_rd_data    (ent_rd_data),
        .ent_wr_en      (ent_wr_en),
        .ent_wr_addr    (ent_wr_addr),
        .ent_wr_data    (ent_wr_data),
        .map_rd_en      (map_rd_en),
        .map_rd_addr    (map_rd_addr),
        .map_rd_data    (map_rd_data),
        .map_scan       (map_scan),
        .map_wr_en      (map_wr_en),
        .map_wr_addr    (map_wr_addr),
        .map_wr_data    (map_wr_data)
    );

    assign status          = rsp.status;
    assign handle_index    = rsp.handle_index;
    assign found_object    = rsp.found_object;
    assign entry_flags     = rsp.entry_flags;
    assign entry_rights    = rsp.entry_rights;
    assign reference_taken = rsp.reference_taken;
    assign released_object = rsp.released_object;

endmodule
